// ===== rtl/tama_pkg.sv =====
// Shared constants for the three-axis moving-average filter.
// No dependencies; imported by the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package tama_pkg;

   localparam int SAMPLE_W = 16;   // bits per axis sample and per axis mean
   localparam int NUM_AXES = 3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage : tama_pkg

`default_nettype wire

// ===== rtl/three_axis_moving_average_top.sv =====
// Three-axis moving-average filter: sample ring, running sums, bit-serial divider.
// Depends on tama_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_sample_x/y/z (signed 16)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_mean_x/y/z (signed 16)
//
// One item at a time: after the input transfer it passes through the update,
// setup, divide and done states, and the result is registered on leaving done.
// The restoring divider, one quotient bit per cycle for all three axes at once,
// works over the signed sum width SW = 17 + clog2(WINDOW).
// Reset (synchronous) clears control, sums, fill count and write position; ring
// entries are read as zero until the ring has filled once, so no clearing pass.
// A stalled result sits in the output register; the next item is still taken,
// and it waits before its final cycle until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_moving_average_top #(
   parameter int WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tama_pkg::sample_type  req_sample_x,
   input  tama_pkg::sample_type  req_sample_y,
   input  tama_pkg::sample_type  req_sample_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tama_pkg::sample_type  rsp_mean_x,
   output tama_pkg::sample_type  rsp_mean_y,
   output tama_pkg::sample_type  rsp_mean_z
);
   import tama_pkg::*;

   localparam int SW = SAMPLE_W + $clog2(WINDOW) + 1;   // signed sum width
   localparam int CW = $clog2(WINDOW + 1);              // fill count / divisor
   localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int KW = $clog2(SW + 1);
   localparam int RW = NUM_AXES * SAMPLE_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_SETUP  = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [KW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            smp_ff [NUM_AXES];
   logic [RW-1:0]         rd_ff;
   logic signed [SW-1:0]  sum_ff [NUM_AXES];
   logic signed [SW-1:0]  sum_in [NUM_AXES];
   logic                  neg_ff [NUM_AXES];
   logic                  neg_in [NUM_AXES];
   logic [SW-1:0]         quo_ff [NUM_AXES];
   logic [SW-1:0]         quo_in [NUM_AXES];
   logic [CW-1:0]         rem_ff [NUM_AXES];
   logic [CW-1:0]         rem_in [NUM_AXES];
   sample_type            mean_ff [NUM_AXES];
   sample_type            mean_in [NUM_AXES];

   logic [RW-1:0]         ring_mem [WINDOW];

   logic                  in_xfer;
   logic                  ring_full;
   logic                  out_free;
   sample_type            old_smp [NUM_AXES];
   logic [CW:0]           trial [NUM_AXES];
   logic [CW:0]           diff [NUM_AXES];
   logic [SAMPLE_W-1:0]   q16 [NUM_AXES];

   assign req_ready  = (state_ff == ST_IDLE);
   assign in_xfer    = req_valid && req_ready;
   assign ring_full  = (fill_ff == CW'(WINDOW));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mean_x = mean_ff[0];
   assign rsp_mean_y = mean_ff[1];
   assign rsp_mean_z = mean_ff[2];

   // ring store: read at transfer, write during the sum update
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         rd_ff <= ring_mem[pos_ff];
      end
      if (state_ff == ST_UPDATE) begin
         ring_mem[pos_ff] <= {smp_ff[2], smp_ff[1], smp_ff[0]};
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      for (int a = 0; a < NUM_AXES; a++) begin
         // slot not yet written since reset reads as zero
         old_smp[a] = ring_full ? sample_type'(rd_ff[a*SAMPLE_W +: SAMPLE_W]) : '0;
         trial[a]   = {rem_ff[a], quo_ff[a][SW-1]};
         diff[a]    = trial[a] - {1'b0, fill_ff};
         q16[a]     = quo_ff[a][SAMPLE_W-1:0];
         sum_in[a]  = sum_ff[a];
         neg_in[a]  = neg_ff[a];
         quo_in[a]  = quo_ff[a];
         rem_in[a]  = rem_ff[a];
         mean_in[a] = mean_ff[a];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int a = 0; a < NUM_AXES; a++) begin
               sum_in[a] = sum_ff[a] - SW'(old_smp[a]) + SW'(smp_ff[a]);
            end
            if (!ring_full) begin
               fill_in = fill_ff + 1'b1;
            end
            pos_in   = (pos_ff == PW'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            for (int a = 0; a < NUM_AXES; a++) begin
               neg_in[a] = sum_ff[a][SW-1];
               quo_in[a] = sum_ff[a][SW-1] ? (~sum_ff[a] + 1'b1) : sum_ff[a];
               rem_in[a] = '0;
            end
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring step: one quotient bit per axis per cycle
            for (int a = 0; a < NUM_AXES; a++) begin
               if (!diff[a][CW]) begin
                  rem_in[a] = diff[a][CW-1:0];
                  quo_in[a] = {quo_ff[a][SW-2:0], 1'b1};
               end else begin
                  rem_in[a] = trial[a][CW-1:0];
                  quo_in[a] = {quo_ff[a][SW-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == KW'(SW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  mean_in[a] = neg_ff[a] ? sample_type'(~q16[a] + 1'b1)
                                         : sample_type'(q16[a]);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int a = 0; a < NUM_AXES; a++) begin
            sum_ff[a] <= sum_in[a];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         smp_ff[0] <= req_sample_x;
         smp_ff[1] <= req_sample_y;
         smp_ff[2] <= req_sample_z;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         neg_ff[a]  <= neg_in[a];
         quo_ff[a]  <= quo_in[a];
         rem_ff[a]  <= rem_in[a];
         mean_ff[a] <= mean_in[a];
      end
   end

endmodule : three_axis_moving_average_top

`default_nettype wire

// ===== rtl/tama_checker.sv =====
// Port-level checker for the three-axis moving-average filter, bound to the top.
// Depends on tama_pkg and three_axis_moving_average_top.
`timescale 1ns / 1ps
`default_nettype none

module tama_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input tama_pkg::sample_type  rsp_mean_x,
   input tama_pkg::sample_type  rsp_mean_y,
   input tama_pkg::sample_type  rsp_mean_z
);
   import tama_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_x)
         && $stable(rsp_mean_y) && $stable(rsp_mean_z))
      else $error("result changed while stalled");

   // no result out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one item in flight: a transfer closes the input until its result is out
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer while an item is in work");

   // a new result only appears once the block is back to taking input
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while an item is still in work");

   // a transfer never yields a result on the very next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early after transfer");

endmodule : tama_checker

bind three_axis_moving_average_top tama_checker u_tama_checker (.*);

`default_nettype wire

// ===== tb/moving_average_checker.sv =====
// Scoreboard for the three-axis moving-average filter: predicts each window mean
// from the observed sample transfers and compares every result transfer.
// Depends on tama_pkg for the sample type.
`timescale 1ns / 1ps

module moving_average_checker #(
   parameter int WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  tama_pkg::sample_type  req_sample_x,
   input  tama_pkg::sample_type  req_sample_y,
   input  tama_pkg::sample_type  req_sample_z,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tama_pkg::sample_type  rsp_mean_x,
   input  tama_pkg::sample_type  rsp_mean_y,
   input  tama_pkg::sample_type  rsp_mean_z,
   output int                    mismatch_count,
   output int                    outstanding
);
   import tama_pkg::*;

   typedef struct packed {
      sample_type x;
      sample_type y;
      sample_type z;
   } mean_set_type;

   // shadow copy of the filter state
   sample_type   ring_x [WINDOW];
   sample_type   ring_y [WINDOW];
   sample_type   ring_z [WINDOW];
   int           sum_x;
   int           sum_y;
   int           sum_z;
   int           fill_count;
   int           write_pos;
   mean_set_type expected_means [$];
   mean_set_type oldest;

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_axis(input string axis, input sample_type got,
                             input sample_type want);
      if (got !== want)
         report_error($sformatf("mean_%s is %0d, expected %0d", axis, got, want));
   endtask

   // Oldest slot drops out, new sample goes in; divisor is the saturating fill.
   function automatic mean_set_type take_sample(input sample_type x, input sample_type y,
                                                input sample_type z);
      mean_set_type m;
      if (fill_count < WINDOW)
         fill_count++;
      sum_x = sum_x - int'(ring_x[write_pos]) + int'(x);
      sum_y = sum_y - int'(ring_y[write_pos]) + int'(y);
      sum_z = sum_z - int'(ring_z[write_pos]) + int'(z);
      ring_x[write_pos] = x;
      ring_y[write_pos] = y;
      ring_z[write_pos] = z;
      // int division truncates toward zero
      m.x = sample_type'(sum_x / fill_count);
      m.y = sample_type'(sum_y / fill_count);
      m.z = sample_type'(sum_z / fill_count);
      write_pos = (write_pos == WINDOW - 1) ? 0 : write_pos + 1;
      return m;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_x[i] = '0;
            ring_y[i] = '0;
            ring_z[i] = '0;
         end
         sum_x = 0;
         sum_y = 0;
         sum_z = 0;
         fill_count = 0;
         write_pos = 0;
         expected_means.delete();
         outstanding <= 0;
      end else begin
         // results first: a result always belongs to an earlier transfer
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               report_error($sformatf("unexpected result %0d %0d %0d",
                                      rsp_mean_x, rsp_mean_y, rsp_mean_z));
            end else begin
               oldest = expected_means.pop_front();
               check_axis("x", rsp_mean_x, oldest.x);
               check_axis("y", rsp_mean_y, oldest.y);
               check_axis("z", rsp_mean_z, oldest.z);
            end
         end
         if (req_valid && req_ready)
            expected_means.push_back(take_sample(req_sample_x, req_sample_y, req_sample_z));
         outstanding <= expected_means.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the moving-average filter testbench: clock, reset, sample stimulus and
// result back-pressure, with the verdict. Depends on tama_pkg, the filter top
// and moving_average_checker.
`timescale 1ns / 1ps

module testbench;
   import tama_pkg::*;

   localparam int WINDOW          = 16;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_valid    = 1'b0;
   sample_type req_sample_x = '0;
   sample_type req_sample_y = '0;
   sample_type req_sample_z = '0;
   logic       rsp_ready    = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   sample_type rsp_mean_x;
   sample_type rsp_mean_y;
   sample_type rsp_mean_z;

   int   sender_idle_pct   = 22;
   int   receiver_idle_pct = 74;
   logic hold_off_request  = 1'b0;
   logic hold_off_taken    = 1'b0;
   int   hold_off_left     = 0;
   int   mismatch_count;
   int   outstanding;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   three_axis_moving_average_top #(.WINDOW(WINDOW)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample_x (req_sample_x),
      .req_sample_y (req_sample_y),
      .req_sample_z (req_sample_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_mean_x   (rsp_mean_x),
      .rsp_mean_y   (rsp_mean_y),
      .rsp_mean_z   (rsp_mean_z)
   );

   moving_average_checker #(.WINDOW(WINDOW)) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_sample_z   (req_sample_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mean_x     (rsp_mean_x),
      .rsp_mean_y     (rsp_mean_y),
      .rsp_mean_z     (rsp_mean_z),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // result side: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         rsp_ready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_request && !hold_off_taken) begin
         rsp_ready <= 1'b0;
         hold_off_left <= HOLD_OFF_CYCLES;
         hold_off_taken <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_sample(input sample_type x, input sample_type y, input sample_type z);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_x <= x;
      req_sample_y <= y;
      req_sample_z <= z;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   function automatic sample_type random_axis();
      case ($urandom_range(5))
         0, 1: return sample_type'($urandom);
         2: begin
            case ($urandom_range(4))
               0: return sample_type'(32767);
               1: return sample_type'(-32768);
               2: return sample_type'(-1);
               3: return sample_type'(1);
               default: return '0;
            endcase
         end
         3: return sample_type'(int'($urandom_range(64)) - 32);
         4: return sample_type'(32767 - int'($urandom_range(255)));
         default: return sample_type'(-32768 + int'($urandom_range(255)));
      endcase
   endfunction

   // Mostly independent samples; now and then a steady run longer than the
   // window so the sums settle on one value, extremes included.
   task automatic send_random_batch(input int count);
      int         sent;
      int         run_len;
      sample_type sx;
      sample_type sy;
      sample_type sz;
      sent = 0;
      while (sent < count) begin
         sx = random_axis();
         sy = random_axis();
         sz = random_axis();
         run_len = ($urandom_range(9) == 0) ? WINDOW + $urandom_range(1, 4) : 1;
         repeat (run_len) begin
            send_sample(sx, sy, sz);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // partial window, negative sum truncated toward zero on the second transfer
      send_sample(-3, 5, 32767);
      send_sample(0, 0, 0);
      send_sample(32767, -32768, -1);
      // fill the ring with rails and wrap the write position
      repeat (WINDOW) send_sample(32767, -32768, 32767);
      repeat (4) send_sample(-32768, 32767, -32768);

      send_random_batch(180);

      sender_idle_pct = 74;
      receiver_idle_pct <= 22;
      send_random_batch(180);

      // no idling; long receiver hold-off while samples keep coming
      sender_idle_pct = 0;
      receiver_idle_pct <= 0;
      hold_off_request <= 1'b1;
      send_random_batch(170);

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
